// ===== src/ccfs_pkg.sv =====
// shared types, codes and reset constants of the capacitor charge and fire sequencer
`timescale 1ns / 1ps

package ccfs_pkg;

   // register file geometry
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam int CsrIndexWidth = 3;

   // register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      REG_CHARGED_COUNT_LIMIT  = 3'd0,
      REG_CHARGE_TIMEOUT_LIMIT = 3'd1,
      REG_FIRE_PULSE_LIMIT     = 3'd2,
      REG_RECOVERY_LIMIT       = 3'd3,
      REG_CHARGE_DUTY          = 3'd4
   } reg_index_type;

   // register reset values
   localparam logic [7:0]  ChargedCountLimitReset  = 8'd3;
   localparam logic [15:0] ChargeTimeoutLimitReset = 16'd150;
   localparam logic [15:0] FirePulseLimitReset     = 16'd50;
   localparam logic [15:0] RecoveryLimitReset      = 16'd500;
   localparam logic [8:0]  ChargeDutyReset         = 9'd80;

   // command words with a meaning
   localparam logic [15:0] CmdOff = 16'd0;
   localparam logic [15:0] CmdOn  = 16'd1;

   // sequencer phases; codes six and seven are unused
   typedef enum logic [2:0] {
      PH_WAIT      = 3'd0,
      PH_CHARGE    = 3'd1,
      PH_CHARGED   = 3'd2,
      PH_FIRE      = 3'd3,
      PH_DISCHARGE = 3'd4,
      PH_RECOVERY  = 3'd5
   } phase_type;

   // configuration seen by the sequencer
   typedef struct packed {
      logic [7:0]  charged_count_limit;
      logic [15:0] charge_timeout_limit;
      logic [15:0] fire_pulse_limit;
      logic [15:0] recovery_limit;
      logic [8:0]  charge_duty;
   } cfg_type;

   // one control tick
   typedef struct packed {
      logic        undervoltage;
      logic [15:0] fire_cmd;
      logic [15:0] charge_cmd;
   } item_type;

   // one result, first field in the highest bits
   typedef struct packed {
      logic [8:0] duty_out;
      logic       gate_on;
      logic       discharge_on;
      logic       timeout_flag;
      logic [2:0] reported_phase;
   } result_type;

   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 16;

endpackage

// ===== src/ccfs_csr.sv =====
// apb-style configuration registers of the sequencer
`timescale 1ns / 1ps

module ccfs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ccfs_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [ccfs_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [ccfs_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output ccfs_pkg::cfg_type                    cfg
);

   ccfs_pkg::cfg_type cfg_ff, cfg_in;
   logic [ccfs_pkg::CsrIndexWidth-1:0] index;
   logic write_en;

   assign index = csr_paddr[ccfs_pkg::CsrAddrWidth-1:2];
   assign write_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   // register write decode; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            ccfs_pkg::REG_CHARGED_COUNT_LIMIT:
               cfg_in.charged_count_limit = csr_pwdata[7:0];
            ccfs_pkg::REG_CHARGE_TIMEOUT_LIMIT:
               cfg_in.charge_timeout_limit = csr_pwdata[15:0];
            ccfs_pkg::REG_FIRE_PULSE_LIMIT:
               cfg_in.fire_pulse_limit = csr_pwdata[15:0];
            ccfs_pkg::REG_RECOVERY_LIMIT:
               cfg_in.recovery_limit = csr_pwdata[15:0];
            ccfs_pkg::REG_CHARGE_DUTY:
               cfg_in.charge_duty = csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charged_count_limit  <= ccfs_pkg::ChargedCountLimitReset;
         cfg_ff.charge_timeout_limit <= ccfs_pkg::ChargeTimeoutLimitReset;
         cfg_ff.fire_pulse_limit     <= ccfs_pkg::FirePulseLimitReset;
         cfg_ff.recovery_limit       <= ccfs_pkg::RecoveryLimitReset;
         cfg_ff.charge_duty          <= ccfs_pkg::ChargeDutyReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      unique case (index)
         ccfs_pkg::REG_CHARGED_COUNT_LIMIT:
            csr_prdata = {24'd0, cfg_ff.charged_count_limit};
         ccfs_pkg::REG_CHARGE_TIMEOUT_LIMIT:
            csr_prdata = {16'd0, cfg_ff.charge_timeout_limit};
         ccfs_pkg::REG_FIRE_PULSE_LIMIT:
            csr_prdata = {16'd0, cfg_ff.fire_pulse_limit};
         ccfs_pkg::REG_RECOVERY_LIMIT:
            csr_prdata = {16'd0, cfg_ff.recovery_limit};
         ccfs_pkg::REG_CHARGE_DUTY:
            csr_prdata = {23'd0, cfg_ff.charge_duty};
         default: csr_prdata = '0;
      endcase
   end

endmodule

// ===== src/ccfs_core.sv =====
// six-phase sequencer state and its next-state logic, one tick per step
`timescale 1ns / 1ps

module ccfs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ccfs_pkg::item_type   item,
   input  ccfs_pkg::cfg_type    cfg,
   output ccfs_pkg::result_type result
);

   ccfs_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic [15:0] charge_ticks_ff, charge_ticks_in;
   logic [7:0]  good_ticks_ff, good_ticks_in;
   logic [15:0] pulse_ticks_ff, pulse_ticks_in;
   logic [15:0] recovery_ticks_ff, recovery_ticks_in;
   logic        timeout_ff, timeout_in;
   logic        discharge_ff, discharge_in;
   logic        gate_ff, gate_in;
   logic [8:0]  duty_ff, duty_in;
   logic        stop_cmd;
   logic        forced;

   assign stop_cmd = (item.charge_cmd == ccfs_pkg::CmdOff);
   assign forced = stop_cmd && (phase_ff == ccfs_pkg::PH_CHARGE ||
                                phase_ff == ccfs_pkg::PH_CHARGED ||
                                phase_ff == ccfs_pkg::PH_FIRE);
   assign eff_phase = forced ? ccfs_pkg::PH_DISCHARGE : phase_ff;

   // phase action for one tick
   always_comb begin
      phase_in          = eff_phase;
      charge_ticks_in   = charge_ticks_ff;
      good_ticks_in     = good_ticks_ff;
      pulse_ticks_in    = pulse_ticks_ff;
      recovery_ticks_in = recovery_ticks_ff;
      timeout_in        = timeout_ff;
      discharge_in      = discharge_ff;
      gate_in           = gate_ff;
      duty_in           = duty_ff;
      unique case (eff_phase)
         ccfs_pkg::PH_WAIT: begin
            charge_ticks_in   = '0;
            good_ticks_in     = '0;
            pulse_ticks_in    = '0;
            recovery_ticks_in = '0;
            discharge_in      = 1'b1;
            if (item.charge_cmd == ccfs_pkg::CmdOn && item.fire_cmd == ccfs_pkg::CmdOff) begin
               phase_in = ccfs_pkg::PH_CHARGE;
            end
         end
         ccfs_pkg::PH_CHARGE: begin
            discharge_in    = 1'b0;
            timeout_in      = 1'b0;
            duty_in         = item.undervoltage ? cfg.charge_duty : 9'd0;
            charge_ticks_in = charge_ticks_ff + 16'd1;
            good_ticks_in   = item.undervoltage ? good_ticks_ff : good_ticks_ff + 8'd1;
            // timeout wins over charged when both happen on one tick
            if (good_ticks_in > cfg.charged_count_limit) begin
               good_ticks_in = '0;
               phase_in      = ccfs_pkg::PH_CHARGED;
            end
            if (charge_ticks_in > cfg.charge_timeout_limit) begin
               timeout_in = 1'b1;
               phase_in   = ccfs_pkg::PH_DISCHARGE;
            end
         end
         ccfs_pkg::PH_CHARGED: begin
            duty_in = item.undervoltage ? cfg.charge_duty : 9'd0;
            if (item.fire_cmd == ccfs_pkg::CmdOn) begin
               phase_in = ccfs_pkg::PH_FIRE;
            end
         end
         ccfs_pkg::PH_FIRE: begin
            gate_in        = 1'b1;
            pulse_ticks_in = pulse_ticks_ff + 16'd1;
            if (pulse_ticks_in > cfg.fire_pulse_limit) begin
               pulse_ticks_in = '0;
               gate_in        = 1'b0;
               phase_in       = ccfs_pkg::PH_DISCHARGE;
            end
         end
         ccfs_pkg::PH_DISCHARGE: begin
            duty_in      = '0;
            discharge_in = 1'b1;
            phase_in     = ccfs_pkg::PH_RECOVERY;
         end
         ccfs_pkg::PH_RECOVERY: begin
            duty_in           = '0;
            discharge_in      = 1'b1;
            recovery_ticks_in = recovery_ticks_ff + 16'd1;
            if (recovery_ticks_in > cfg.recovery_limit) begin
               recovery_ticks_in = '0;
               phase_in          = ccfs_pkg::PH_WAIT;
            end
         end
         // unused codes fall into discharge
         default: phase_in = ccfs_pkg::PH_DISCHARGE;
      endcase
   end

   // result of this tick
   always_comb begin
      result.reported_phase = phase_ff;
      result.timeout_flag   = timeout_in;
      result.discharge_on   = discharge_in;
      result.gate_on        = gate_in;
      result.duty_out       = duty_in;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= ccfs_pkg::PH_WAIT;
         charge_ticks_ff   <= '0;
         good_ticks_ff     <= '0;
         pulse_ticks_ff    <= '0;
         recovery_ticks_ff <= '0;
         timeout_ff        <= 1'b0;
         discharge_ff      <= 1'b1;
         gate_ff           <= 1'b0;
         duty_ff           <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         charge_ticks_ff   <= charge_ticks_in;
         good_ticks_ff     <= good_ticks_in;
         pulse_ticks_ff    <= pulse_ticks_in;
         recovery_ticks_ff <= recovery_ticks_in;
         timeout_ff        <= timeout_in;
         discharge_ff      <= discharge_in;
         gate_ff           <= gate_in;
         duty_ff           <= duty_in;
      end
   end

endmodule

// ===== src/capacitor_charge_fire_sequencer_unit.sv =====
// top level of the capacitor charge and fire sequencer: stream ports, input and result registers
`timescale 1ns / 1ps

// Each req beat is one control tick (charge command, fire command, undervoltage pin) and yields
// exactly one rsp beat with the phase before the tick and the switch, gate and duty levels after
// it. The block takes one beat per clock cycle when the result side keeps up; a beat is captured
// in the input register and is then stepped through the sequencer into the result register.
// The result register holds a waiting beat while the input register takes the next one. The
// user must write registers through the csr port only while no beat is in flight; the block
// itself does not enforce this. pready is always high.

module capacitor_charge_fire_sequencer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: charge_cmd[15:0], fire_cmd[31:16], undervoltage[32], zero[39:33]
   input  logic [ccfs_pkg::ReqDataWidth-1:0]     req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: reported_phase[2:0], timeout_flag[3], discharge_on[4], gate_on[5],
   //        duty_out[14:6], zero[15]
   output logic [ccfs_pkg::RspDataWidth-1:0]     rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ccfs_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [ccfs_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [ccfs_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   ccfs_pkg::cfg_type    cfg;
   ccfs_pkg::item_type   item_ff;
   ccfs_pkg::result_type result;
   ccfs_pkg::result_type result_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 req_beat;

   ccfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: step when the result register is free or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_beat     = req_tvalid && req_tready;
   assign in_valid_in  = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= req_tdata[$bits(ccfs_pkg::item_type)-1:0];
      end
   end

   ccfs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ccfs_pkg::RspDataWidth - $bits(ccfs_pkg::result_type)){1'b0}},
                        result_ff};

endmodule
